@@ rtl/core/shcd_pkg.sv @@
// ============================================================================
// shcd_pkg: shared types and constants of the stereo hard-clip distortion
// Operation codes, controller-to-datapath command word, register indexes
// and the fixed widths of the internal Q1.31 arithmetic.
// ============================================================================
package shcd_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECLIP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSTCLIP = 2'd3;

    localparam logic [CFG_DATA_W-1:0] HIGHPASS_RESET = 16'd300;
    localparam logic [CFG_DATA_W-1:0] DRIVE_RESET    = 16'd25600;
    localparam logic [CFG_DATA_W-1:0] PRECLIP_RESET  = 16'd6516;
    localparam logic [CFG_DATA_W-1:0] POSTCLIP_RESET = 16'd5738;

    // Internal levels: Q1.31 for full scale, Q9.31 for the pre-clip level
    localparam int LVL_W  = 32;
    localparam int PRE_W  = 40;
    localparam int DRV_SHIFT = 8;

    // Shared multiplier: signed A times signed B
    localparam int MUL_A_W = PRE_W + 1;
    localparam int MUL_B_W = CFG_DATA_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Output level 0.26 in Q0.16
    localparam int OUT_LEVEL_SHIFT = 16;
    localparam logic [MUL_B_W-1:0] OUT_LEVEL = 17'd17039;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DC_MUL,
        OP_DC_UPD,
        OP_DRV_MUL,
        OP_DRV_SAT,
        OP_PRE_MUL,
        OP_PRE_UPD,
        OP_POST_MUL,
        OP_POST_UPD,
        OP_OUT_MUL,
        OP_OUT_WR
    } op_t;

    typedef struct packed {
        logic capture;
        logic ch;
        op_t  op;
    } cmd_t;

endpackage

@@ rtl/core/stereo_hard_clip_distortion_core.sv @@
// ============================================================================
// stereo_hard_clip_distortion_core: stereo one-pole filtered hard clipper
// Top level joining the step sequencer and the shared-multiplier datapath.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready, left_sample, right_sample) takes one
//   stereo word of signed Q1.23 samples. The output channel (out_valid/
//   out_ready, left_out, right_out) returns one distorted stereo word for each
//   input word, in order.
//   Each channel runs: DC-blocking high-pass, drive gain with saturation,
//   pre-clip low-pass, hard clip to full scale, post-clip low-pass, level 0.26.
//   Throughput: the result of an accepted word becomes valid when in_ready
//   rises again, so a new word is taken only once the last one is through.
//   The pace is set by the single shared multiplier: ten steps per channel, a
//   multiply followed by an update for each filter, the drive saturation and
//   the output scaling.
//   A finished word sits in the output register; the next input word is taken
//   and processed meanwhile. If the receiver still stalls when the next
//   result is ready, the sequencer holds on its last step until the output
//   register frees up.
//   Reset clears all filter levels to zero, loads the default coefficients
//   and drive, and drops any word in flight.
//   Configuration (cfg_we, cfg_index, cfg_data) is to be written only while
//   idle (the block does not enforce it); indexes above three are ignored.
// ============================================================================
module stereo_hard_clip_distortion_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [shcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shcd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   left_sample,
    input  logic signed [SAMPLE_BITS-1:0]   right_sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   left_out,
    output logic signed [SAMPLE_BITS-1:0]   right_out
);

    // Command word from sequencer to datapath: capture strobe, channel, step
    shcd_pkg::cmd_t cmd;

    shcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    shcd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .left_out     (left_out),
        .right_out    (right_out)
    );

endmodule

@@ rtl/core/shcd_datapath.sv @@
// ============================================================================
// shcd_datapath: shared-multiplier datapath of the stereo hard-clip distortion
// Holds the configuration registers, the per-channel filter levels and one
// registered multiplier that every filter step goes through.
// ============================================================================
module shcd_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [shcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shcd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]   left_sample,
    input  logic signed [SAMPLE_BITS-1:0]   right_sample,
    input  shcd_pkg::cmd_t                  cmd,
    output logic signed [SAMPLE_BITS-1:0]   left_out,
    output logic signed [SAMPLE_BITS-1:0]   right_out
);

    localparam int LVL_W   = shcd_pkg::LVL_W;
    localparam int PRE_W   = shcd_pkg::PRE_W;
    localparam int A_W     = shcd_pkg::MUL_A_W;
    localparam int B_W     = shcd_pkg::MUL_B_W;
    localparam int P_W     = shcd_pkg::PROD_W;
    localparam int CW      = shcd_pkg::CFG_DATA_W;
    localparam int IN_SHIFT  = LVL_W - SAMPLE_BITS;
    localparam int OUT_SHIFT = shcd_pkg::OUT_LEVEL_SHIFT + LVL_W - SAMPLE_BITS;
    localparam logic [CW-1:0] COEF_MASK =
        (COEF_BITS >= CW) ? {CW{1'b1}} : CW'((32'd1 << COEF_BITS) - 32'd1);
    localparam logic signed [PRE_W-1:0] PRE_MAX = {1'b0, {(PRE_W-1){1'b1}}};
    localparam logic signed [PRE_W-1:0] PRE_MIN = {1'b1, {(PRE_W-1){1'b0}}};
    localparam logic signed [LVL_W-1:0] CLIP_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] CLIP_MIN = {1'b1, {(LVL_W-1){1'b0}}};

    // Configuration
    logic [CW-1:0] hp_coef_reg;
    logic [CW-1:0] drive_reg;
    logic [CW-1:0] pre_coef_reg;
    logic [CW-1:0] post_coef_reg;

    // Per-channel state
    logic signed [LVL_W-1:0] dc_reg   [2];
    logic signed [PRE_W-1:0] pre_reg  [2];
    logic signed [LVL_W-1:0] post_reg [2];

    // Working registers
    logic signed [LVL_W-1:0]       x_reg    [2];
    logic signed [P_W-1:0]         prod_reg;
    logic signed [PRE_W-1:0]       drv_reg;
    logic signed [SAMPLE_BITS-1:0] hold_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    logic signed [LVL_W-1:0]       x_cur;
    logic signed [LVL_W-1:0]       dc_cur;
    logic signed [PRE_W-1:0]       pre_cur;
    logic signed [LVL_W-1:0]       post_cur;
    logic signed [LVL_W:0]         hp_diff;
    logic signed [LVL_W:0]         post_diff;
    logic signed [LVL_W-1:0]       clip_val;
    logic signed [A_W-1:0]         mul_a;
    logic signed [B_W-1:0]         mul_b;
    logic signed [P_W-1:0]         prod_next;
    logic signed [P_W-1:0]         prod_coef;
    logic signed [P_W-1:0]         prod_drv;
    logic signed [P_W-1:0]         prod_out;
    logic signed [LVL_W-1:0]       dc_next;
    logic signed [PRE_W-1:0]       pre_next;
    logic signed [LVL_W-1:0]       post_next;
    logic signed [PRE_W-1:0]       drv_next;
    logic signed [LVL_W-1:0]       x_left_next;
    logic signed [LVL_W-1:0]       x_right_next;

    always_comb
    begin
        x_cur    = x_reg[cmd.ch];
        dc_cur   = dc_reg[cmd.ch];
        pre_cur  = pre_reg[cmd.ch];
        post_cur = post_reg[cmd.ch];

        x_left_next  = LVL_W'(left_sample)  <<< IN_SHIFT;
        x_right_next = LVL_W'(right_sample) <<< IN_SHIFT;

        hp_diff = {x_cur[LVL_W-1], x_cur} - {dc_cur[LVL_W-1], dc_cur};

        // Hard clip to full scale
        if (pre_cur[PRE_W-1:LVL_W-1] != {(PRE_W-LVL_W+1){pre_cur[PRE_W-1]}})
        begin
            clip_val = pre_cur[PRE_W-1] ? CLIP_MIN : CLIP_MAX;
        end
        else
        begin
            clip_val = pre_cur[LVL_W-1:0];
        end

        post_diff = {clip_val[LVL_W-1], clip_val} - {post_cur[LVL_W-1], post_cur};

        // Operand select for the shared multiplier
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            shcd_pkg::OP_DC_MUL:
            begin
                mul_a = A_W'(hp_diff);
                mul_b = {1'b0, hp_coef_reg & COEF_MASK};
            end
            shcd_pkg::OP_DRV_MUL:
            begin
                mul_a = A_W'(hp_diff);
                mul_b = {1'b0, drive_reg};
            end
            shcd_pkg::OP_PRE_MUL:
            begin
                mul_a = {drv_reg[PRE_W-1], drv_reg} - {pre_cur[PRE_W-1], pre_cur};
                mul_b = {1'b0, pre_coef_reg & COEF_MASK};
            end
            shcd_pkg::OP_POST_MUL:
            begin
                mul_a = A_W'(post_diff);
                mul_b = {1'b0, post_coef_reg & COEF_MASK};
            end
            shcd_pkg::OP_OUT_MUL:
            begin
                mul_a = A_W'(post_cur);
                mul_b = shcd_pkg::OUT_LEVEL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        // Level updates from the registered product
        prod_coef = prod_reg >>> COEF_BITS;
        prod_drv  = prod_reg >>> shcd_pkg::DRV_SHIFT;
        prod_out  = prod_reg >>> OUT_SHIFT;
        dc_next   = dc_cur + prod_coef[LVL_W-1:0];
        pre_next  = pre_cur + prod_coef[PRE_W-1:0];
        post_next = post_cur + prod_coef[LVL_W-1:0];

        // Saturate the driven value to the pre-clip accumulator range
        if (prod_drv[P_W-1:PRE_W-1] != {(P_W-PRE_W+1){prod_drv[P_W-1]}})
        begin
            drv_next = prod_drv[P_W-1] ? PRE_MIN : PRE_MAX;
        end
        else
        begin
            drv_next = prod_drv[PRE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_coef_reg   <= shcd_pkg::HIGHPASS_RESET;
            drive_reg     <= shcd_pkg::DRIVE_RESET;
            pre_coef_reg  <= shcd_pkg::PRECLIP_RESET;
            post_coef_reg <= shcd_pkg::POSTCLIP_RESET;
            for (int i = 0; i < 2; i++)
            begin
                dc_reg[i]   <= '0;
                pre_reg[i]  <= '0;
                post_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    shcd_pkg::REG_HIGHPASS: hp_coef_reg   <= cfg_data;
                    shcd_pkg::REG_DRIVE:    drive_reg     <= cfg_data;
                    shcd_pkg::REG_PRECLIP:  pre_coef_reg  <= cfg_data;
                    shcd_pkg::REG_POSTCLIP: post_coef_reg <= cfg_data;
                    default:                hp_coef_reg   <= hp_coef_reg;
                endcase
            end
            if (cmd.op == shcd_pkg::OP_DC_UPD)
            begin
                dc_reg[cmd.ch] <= dc_next;
            end
            if (cmd.op == shcd_pkg::OP_PRE_UPD)
            begin
                pre_reg[cmd.ch] <= pre_next;
            end
            if (cmd.op == shcd_pkg::OP_POST_UPD)
            begin
                post_reg[cmd.ch] <= post_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg[0] <= x_left_next;
            x_reg[1] <= x_right_next;
        end
        // Hold the product while the sequencer waits on the output register
        if (cmd.op != shcd_pkg::OP_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.op == shcd_pkg::OP_DRV_SAT)
        begin
            drv_reg <= drv_next;
        end
        if (cmd.op == shcd_pkg::OP_OUT_WR)
        begin
            if (cmd.ch)
            begin
                left_out_reg  <= hold_reg;
                right_out_reg <= prod_out[SAMPLE_BITS-1:0];
            end
            else
            begin
                hold_reg <= prod_out[SAMPLE_BITS-1:0];
            end
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

@@ rtl/core/shcd_ctrl.sv @@
// ============================================================================
// shcd_ctrl: step sequencer of the stereo hard-clip distortion
// Walks ten datapath steps per channel, left then right, and owns the
// input and output handshakes.
// ============================================================================
module shcd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output shcd_pkg::cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_DC_MUL   = 11'b000_0000_0010,
        ST_DC_UPD   = 11'b000_0000_0100,
        ST_DRV_MUL  = 11'b000_0000_1000,
        ST_DRV_SAT  = 11'b000_0001_0000,
        ST_PRE_MUL  = 11'b000_0010_0000,
        ST_PRE_UPD  = 11'b000_0100_0000,
        ST_POST_MUL = 11'b000_1000_0000,
        ST_POST_UPD = 11'b001_0000_0000,
        ST_OUT_MUL  = 11'b010_0000_0000,
        ST_OUT_WR   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ch_reg;
    logic   ch_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.capture    = 1'b0;
        cmd.ch         = ch_reg;
        cmd.op         = shcd_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                ch_next     = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_DC_MUL;
                end
            end
            ST_DC_MUL:
            begin
                cmd.op     = shcd_pkg::OP_DC_MUL;
                state_next = ST_DC_UPD;
            end
            ST_DC_UPD:
            begin
                cmd.op     = shcd_pkg::OP_DC_UPD;
                state_next = ST_DRV_MUL;
            end
            ST_DRV_MUL:
            begin
                cmd.op     = shcd_pkg::OP_DRV_MUL;
                state_next = ST_DRV_SAT;
            end
            ST_DRV_SAT:
            begin
                cmd.op     = shcd_pkg::OP_DRV_SAT;
                state_next = ST_PRE_MUL;
            end
            ST_PRE_MUL:
            begin
                cmd.op     = shcd_pkg::OP_PRE_MUL;
                state_next = ST_PRE_UPD;
            end
            ST_PRE_UPD:
            begin
                cmd.op     = shcd_pkg::OP_PRE_UPD;
                state_next = ST_POST_MUL;
            end
            ST_POST_MUL:
            begin
                cmd.op     = shcd_pkg::OP_POST_MUL;
                state_next = ST_POST_UPD;
            end
            ST_POST_UPD:
            begin
                cmd.op     = shcd_pkg::OP_POST_UPD;
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                cmd.op     = shcd_pkg::OP_OUT_MUL;
                state_next = ST_OUT_WR;
            end
            ST_OUT_WR:
            begin
                if (!ch_reg)
                begin
                    cmd.op     = shcd_pkg::OP_OUT_WR;
                    ch_next    = 1'b1;
                    state_next = ST_DC_MUL;
                end
                else if (out_free)
                begin
                    // Load the output word; hold here while the receiver stalls
                    cmd.op         = shcd_pkg::OP_OUT_WR;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
